// ===== rtl/oupi_pkg.sv =====
// ----------------------------------------------------------------------------
// oupi_pkg
// Shared types, constants and helper functions of the offset-point unicycle
// pose integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package oupi_pkg;

    // CORDIC iteration count, capped at the length of the arctangent table
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORD_ITERS   = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int CNT_W        = 5;

    // Datapath widths
    localparam int CORD_W  = 34;            // Q2.30 plus guard bits
    localparam int C16_W   = 18;            // cos/sin rounded to Q.16
    localparam int W16_W   = 19;            // turn rate in Q.16 radians
    localparam int BW_W    = 35;            // b*w in Q.28
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W;

    // Arithmetic constants
    localparam logic signed [CORD_W-1:0]  GAIN_Q30    = 34'sd652032874;
    localparam logic signed [CORD_W-1:0]  QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CORD_W-1:0]  HALF_TURN   = 34'sd2147483648;
    localparam logic signed [MUL_B_W-1:0] TWO_PI_Q16  = 20'sd411775;
    localparam logic signed [ACC_W-1:0]   SAT_HI      = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0]   SAT_LO      = ACC_W'(-64'sd2147483648);

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 2'd1;
    localparam logic [15:0] STEP_TIME_RST = 16'd6554;

    // Main sequencer
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CORD = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // Multiply phase steps, one shared multiplier
    typedef enum logic [8:0] {
        M_RND  = 9'b000000001,
        M_CV   = 9'b000000010,
        M_SBW  = 9'b000000100,
        M_SV   = 9'b000001000,
        M_CBW  = 9'b000010000,
        M_VXDT = 9'b000100000,
        M_POSX = 9'b001000000,
        M_VYDT = 9'b010000000,
        M_POSY = 9'b100000000
    } mstep_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic signed [CORD_W-1:0] atan_turn(input logic [CNT_W-1:0] i);
        logic signed [CORD_W-1:0] a;
        case (i)
            5'd0:    a = 34'sh20000000;
            5'd1:    a = 34'sh12E4051E;
            5'd2:    a = 34'sh09FB385B;
            5'd3:    a = 34'sh051111D4;
            5'd4:    a = 34'sh028B0D43;
            5'd5:    a = 34'sh0145D7E1;
            5'd6:    a = 34'sh00A2F61E;
            5'd7:    a = 34'sh00517C55;
            5'd8:    a = 34'sh0028BE53;
            5'd9:    a = 34'sh00145F2F;
            5'd10:   a = 34'sh000A2F98;
            5'd11:   a = 34'sh000517CC;
            5'd12:   a = 34'sh00028BE6;
            5'd13:   a = 34'sh000145F3;
            5'd14:   a = 34'sh0000A2FA;
            5'd15:   a = 34'sh0000517D;
            5'd16:   a = 34'sh000028BE;
            5'd17:   a = 34'sh0000145F;
            5'd18:   a = 34'sh00000A30;
            5'd19:   a = 34'sh00000518;
            5'd20:   a = 34'sh0000028C;
            5'd21:   a = 34'sh00000146;
            5'd22:   a = 34'sh000000A3;
            5'd23:   a = 34'sh00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = 32'sh7FFF_FFFF;
        else if (v < SAT_LO)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/oupi_if.sv =====
// ----------------------------------------------------------------------------
// oupi_if
// Valid/ready channels of the pose integrator: sample in, pose out, and the
// configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface oupi_in_if;
    logic               valid;
    logic               ready;
    logic               start_req;
    logic signed [15:0] speed;
    logic signed [15:0] turn;

    modport source (output valid, start_req, speed, turn, input ready);
    modport sink   (input valid, start_req, speed, turn, output ready);
endinterface

interface oupi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;

    modport source (output valid, pos_x, pos_y, heading, vel_x, vel_y, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, vel_x, vel_y, output ready);
endinterface

interface oupi_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/offset_unicycle_pose_integrator.sv =====
// ----------------------------------------------------------------------------
// offset_unicycle_pose_integrator
// Dead reckoning of an offset control point: heading update, CORDIC sin/cos,
// velocity of the control point and saturating position integration.
// ----------------------------------------------------------------------------
// One sample beat is taken at a time. A normal sample runs through the iterative
// CORDIC rotator, then nine steps of the single shared 36x20 multiplier, then
// hands over the pose beat, waiting until it is taken, and returns to idle.
// The turn-rate and b*w products are formed on the multiplier while the CORDIC
// runs. A start beat clears the pose and returns it in the next cycle.
// Configuration writes are always accepted and must only be issued while no
// sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module offset_unicycle_pose_integrator
    import oupi_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    oupi_in_if.sink    sample,
    oupi_out_if.source pose,
    oupi_cfg_if.sink   cfg
);

    // Steps of the CORDIC phase at which the multiplier builds w and b*w
    localparam logic [CNT_W-1:0] CS_W_MUL   = CNT_W'(0);
    localparam logic [CNT_W-1:0] CS_W_TAKE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CS_BW_MUL  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CS_BW_TAKE = CNT_W'(3);
    localparam logic [CNT_W-1:0] CS_LAST    = CNT_W'(CORD_ITERS - 1);

    // Control and state registers
    state_t                    state_reg,   state_next;
    mstep_t                    mstep_reg,   mstep_next;
    logic [CNT_W-1:0]          cnt_reg,     cnt_next;
    logic signed [31:0]        cur_x_reg,   cur_x_next;
    logic signed [31:0]        cur_y_reg,   cur_y_next;
    logic        [15:0]        cur_hd_reg,  cur_hd_next;
    logic signed [15:0]        off_b_reg,   off_b_next;
    logic        [15:0]        dt_reg,      dt_next;

    // Datapath registers
    logic signed [15:0]        speed_reg,   speed_next;
    logic signed [15:0]        turn_reg,    turn_next;
    logic signed [CORD_W-1:0]  x_reg,       x_next;
    logic signed [CORD_W-1:0]  y_reg,       y_next;
    logic signed [CORD_W-1:0]  z_reg,       z_next;
    logic                      flip_reg,    flip_next;
    logic signed [W16_W-1:0]   w16_reg,     w16_next;
    logic signed [BW_W-1:0]    bw_reg,      bw_next;
    logic signed [C16_W-1:0]   c16_reg,     c16_next;
    logic signed [C16_W-1:0]   s16_reg,     s16_next;
    logic signed [ACC_W-1:0]   accx_reg,    accx_next;
    logic signed [ACC_W-1:0]   accy_reg,    accy_next;
    logic signed [31:0]        vx_reg,      vx_next;
    logic signed [31:0]        vy_reg,      vy_next;
    logic signed [PROD_W-1:0]  prod_reg,    prod_next;

    // Combinational helpers
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic        [15:0]        hd_sum;
    logic signed [CORD_W-1:0]  z_init;
    logic signed [CORD_W-1:0]  dx, dy, ang;
    logic signed [CORD_W-1:0]  cx, sy;
    logic signed [CORD_W-1:0]  c_rnd, s_rnd;
    logic signed [PROD_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]   vx_rnd, vy_rnd;
    logic signed [PROD_W-1:0]  dpos;
    logic signed [ACC_W-1:0]   pos_sum_x, pos_sum_y;
    logic                      in_beat, out_beat;

    assign in_beat  = sample.valid && sample.ready;
    assign out_beat = pose.valid && pose.ready;

    // Heading update and the unfolded CORDIC start angle
    assign hd_sum = cur_hd_reg + sample.turn;
    assign z_init = CORD_W'(signed'({hd_sum, 16'h0000}));

    // CORDIC micro-rotation terms
    assign dx  = y_reg >>> cnt_reg;
    assign dy  = x_reg >>> cnt_reg;
    assign ang = atan_turn(cnt_reg);

    // Undo the half-turn fold, then round Q2.30 to Q.16
    assign cx    = flip_reg ? -x_reg : x_reg;
    assign sy    = flip_reg ? -y_reg : y_reg;
    assign c_rnd = (cx + CORD_W'(34'sd8192)) >>> 14;
    assign s_rnd = (sy + CORD_W'(34'sd8192)) >>> 14;

    // Rounding of the shared multiplier output
    assign w_rnd     = (prod_reg + PROD_W'(64'sd32768)) >>> 16;
    assign dpos      = (prod_reg + PROD_W'(64'sd32768)) >>> 16;
    assign vx_rnd    = (accx_reg + ACC_W'(64'sd134217728)) >>> 28;
    assign vy_rnd    = (accy_reg + ACC_W'(64'sd134217728)) >>> 28;
    assign pos_sum_x = ACC_W'(cur_x_reg) + dpos;
    assign pos_sum_y = ACC_W'(cur_y_reg) + dpos;

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CORD)
        begin
            if (cnt_reg == CS_W_MUL)
            begin
                mul_a = MUL_A_W'(turn_reg);
                mul_b = TWO_PI_Q16;
            end
            else if (cnt_reg == CS_BW_MUL)
            begin
                mul_a = MUL_A_W'(w16_reg);
                mul_b = MUL_B_W'(off_b_reg);
            end
        end
        else if (state_reg == ST_MUL)
        begin
            case (mstep_reg)
                M_CV:
                begin
                    mul_a = MUL_A_W'(c16_reg);
                    mul_b = MUL_B_W'(speed_reg);
                end
                M_SBW:
                begin
                    mul_a = MUL_A_W'(bw_reg);
                    mul_b = MUL_B_W'(s16_reg);
                end
                M_SV:
                begin
                    mul_a = MUL_A_W'(s16_reg);
                    mul_b = MUL_B_W'(speed_reg);
                end
                M_CBW:
                begin
                    mul_a = MUL_A_W'(bw_reg);
                    mul_b = MUL_B_W'(c16_reg);
                end
                M_VXDT:
                begin
                    mul_a = MUL_A_W'(vx_reg);
                    mul_b = {4'b0000, dt_reg};
                end
                M_VYDT:
                begin
                    mul_a = MUL_A_W'(vy_reg);
                    mul_b = {4'b0000, dt_reg};
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign prod_next = mul_a * mul_b;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next  = state_reg;
        mstep_next  = mstep_reg;
        cnt_next    = cnt_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        cur_hd_next = cur_hd_reg;
        off_b_next  = off_b_reg;
        dt_next     = dt_reg;
        speed_next  = speed_reg;
        turn_next   = turn_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        flip_next   = flip_reg;
        w16_next    = w16_reg;
        bw_next     = bw_reg;
        c16_next    = c16_reg;
        s16_next    = s16_reg;
        accx_next   = accx_reg;
        accy_next   = accy_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;

        // Register writes; unknown indexes are dropped
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_OFFSET_B:  off_b_next = cfg.data;
                CFG_STEP_TIME: dt_next    = cfg.data;
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (sample.start_req)
                    begin
                        cur_x_next  = '0;
                        cur_y_next  = '0;
                        cur_hd_next = '0;
                        vx_next     = '0;
                        vy_next     = '0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        speed_next  = sample.speed;
                        turn_next   = sample.turn;
                        cur_hd_next = hd_sum;
                        x_next      = GAIN_Q30;
                        y_next      = '0;
                        cnt_next    = '0;
                        if (z_init > QUARTER_TURN)
                        begin
                            z_next    = z_init - HALF_TURN;
                            flip_next = 1'b1;
                        end
                        else if (z_init < -QUARTER_TURN)
                        begin
                            z_next    = z_init + HALF_TURN;
                            flip_next = 1'b1;
                        end
                        else
                        begin
                            z_next    = z_init;
                            flip_next = 1'b0;
                        end
                        state_next  = ST_CORD;
                    end
                end
            end

            ST_CORD:
            begin
                // one rotation per cycle
                if (!z_reg[CORD_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - ang;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + ang;
                end
                // w and b*w ride along on the idle multiplier
                if (cnt_reg == CS_W_TAKE)
                    w16_next = w_rnd[W16_W-1:0];
                if (cnt_reg == CS_BW_TAKE)
                    bw_next = prod_reg[BW_W-1:0];
                if (cnt_reg == CS_LAST)
                begin
                    mstep_next = M_RND;
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_MUL:
            begin
                mstep_next = mstep_t'(mstep_reg << 1);
                case (mstep_reg)
                    M_RND:
                    begin
                        c16_next = c_rnd[C16_W-1:0];
                        s16_next = s_rnd[C16_W-1:0];
                    end
                    M_CV:   ;
                    M_SBW:  accx_next = prod_reg <<< 16;
                    M_SV:   accx_next = accx_reg - prod_reg;
                    M_CBW:
                    begin
                        accy_next = prod_reg <<< 16;
                        vx_next   = sat32(vx_rnd);
                    end
                    M_VXDT: accy_next = accy_reg + prod_reg;
                    M_POSX:
                    begin
                        cur_x_next = sat32(pos_sum_x);
                        vy_next    = sat32(vy_rnd);
                    end
                    M_VYDT: ;
                    M_POSY:
                    begin
                        cur_y_next = sat32(pos_sum_y);
                        mstep_next = M_RND;
                        state_next = ST_DONE;
                    end
                    default: mstep_next = M_RND;
                endcase
            end

            ST_DONE:
            begin
                if (out_beat)
                    state_next = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mstep_reg  <= M_RND;
            cnt_reg    <= '0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            cur_hd_reg <= '0;
            off_b_reg  <= '0;
            dt_reg     <= STEP_TIME_RST;
        end
        else
        begin
            state_reg  <= state_next;
            mstep_reg  <= mstep_next;
            cnt_reg    <= cnt_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            cur_hd_reg <= cur_hd_next;
            off_b_reg  <= off_b_next;
            dt_reg     <= dt_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        speed_reg <= speed_next;
        turn_reg  <= turn_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        flip_reg  <= flip_next;
        w16_reg   <= w16_next;
        bw_reg    <= bw_next;
        c16_reg   <= c16_next;
        s16_reg   <= s16_next;
        accx_reg  <= accx_next;
        accy_reg  <= accy_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        prod_reg  <= prod_next;
    end

    // Ports
    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign pose.valid   = (state_reg == ST_DONE);
    assign pose.pos_x   = cur_x_reg;
    assign pose.pos_y   = cur_y_reg;
    assign pose.heading = cur_hd_reg;
    assign pose.vel_x   = vx_reg;
    assign pose.vel_y   = vy_reg;

    // Checks
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && sample.start_req) |=>
            (pose.valid && pose.pos_x == 0 && pose.pos_y == 0 && pose.heading == 0
             && pose.vel_x == 0 && pose.vel_y == 0))
        else $error("start beat did not return a zero pose");

    a_heading_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !sample.start_req) |=>
            (state_reg == ST_CORD && cnt_reg == '0
             && cur_hd_reg == $past(cur_hd_reg + sample.turn)))
        else $error("sample beat did not advance the heading");

    a_cord_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORD) |-> (cnt_reg <= CS_LAST))
        else $error("CORDIC step count overran");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(sample.ready && pose.valid))
        else $error("sample taken while a pose beat is pending");

endmodule

`default_nettype wire

// ===== tb/sv/oupi_pose_checker.sv =====
// ----------------------------------------------------------------------------
// oupi_pose_checker
// Watches the sample, pose and configuration channels of the pose integrator,
// predicts every pose beat and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module oupi_pose_checker
    import oupi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    oupi_in_if        sample,
    oupi_out_if       pose,
    oupi_cfg_if       cfg,
    output int        fail_count,
    output int        pending,
    output int        beats_checked,
    output int        start_beats,
    output int        clamp_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    // Rotator constants: gain in Q30, angles as 32-bit binary angle
    localparam int     ATAN_DEPTH   = 24;
    localparam int     ROT_STEPS    = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
    localparam longint ROT_GAIN     = 64'sd652032874;
    localparam longint ROT_QUARTER  = 64'sd1073741824;
    localparam longint ROT_HALF     = 64'sd2147483648;
    localparam longint RAD_PER_TURN = 64'sd411775;
    localparam longint POS_MAX      = 64'sd2147483647;
    localparam longint POS_MIN      = -64'sd2147483648;
    localparam logic [15:0] STEP_TIME_DEFAULT = 16'd6554;

    localparam longint ATAN_TURNS [ATAN_DEPTH] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } pose_beat_t;

    // Predicted pose beats, oldest first
    pose_beat_t expected_poses [$];
    pose_beat_t due_beat;
    pose_beat_t new_beat;
    int         field_errs;

    // Shadow registers and tracked pose
    logic signed [15:0] reg_offset_b;
    logic        [15:0] reg_step_time;
    logic signed [31:0] track_x;
    logic signed [31:0] track_y;
    logic        [15:0] track_heading;

    // Add half, then floor
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > POS_MAX)
            return 32'sh7FFF_FFFF;
        if (v < POS_MIN)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Rotation-mode CORDIC; beyond a quarter turn rotate by half and negate
    function automatic void heading_to_cos_sin(input logic [15:0] h,
                                               output longint c, output longint s);
        logic signed [31:0] ang;
        longint             z;
        longint             x;
        longint             y;
        longint             dx;
        longint             dy;
        bit                 mirrored;
        ang      = {h, 16'h0000};
        z        = ang;
        x        = ROT_GAIN;
        y        = 0;
        mirrored = 1'b0;
        if (z > ROT_QUARTER)
        begin
            z        = z - ROT_HALF;
            mirrored = 1'b1;
        end
        else if (z < -ROT_QUARTER)
        begin
            z        = z + ROT_HALF;
            mirrored = 1'b1;
        end
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURNS[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURNS[i];
            end
        end
        if (mirrored)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    // Advance the tracked pose by one sample and return the beat it reports
    function automatic pose_beat_t integrate_sample(input logic st,
                                                    input logic signed [15:0] spd,
                                                    input logic signed [15:0] trn);
        pose_beat_t         r;
        logic signed [31:0] vel_x_q;
        logic signed [31:0] vel_y_q;
        longint             v, t, b, dt;
        longint             c30, s30, c16, s16, w16, bw, sx, sy, vx, vy, px, py;
        r = '0;
        if (st)
        begin
            track_x       = '0;
            track_y       = '0;
            track_heading = '0;
            return r;
        end
        v  = spd;
        t  = trn;
        b  = reg_offset_b;
        dt = reg_step_time;
        track_heading = track_heading + trn;

        heading_to_cos_sin(track_heading, c30, s30);
        c16 = round_half_up(c30, 14);
        s16 = round_half_up(s30, 14);
        w16 = round_half_up(t * RAD_PER_TURN, 16);
        bw  = b * w16;

        // Control point velocity, exact in Q.44 then rounded to Q16.16
        sx = c16 * v * 64'sd65536 - s16 * bw;
        sy = s16 * v * 64'sd65536 + c16 * bw;
        vel_x_q = clamp32(round_half_up(sx, 28));
        vel_y_q = clamp32(round_half_up(sy, 28));
        vx = vel_x_q;
        vy = vel_y_q;

        px = track_x;
        py = track_y;
        track_x = clamp32(px + round_half_up(vx * dt, 16));
        track_y = clamp32(py + round_half_up(vy * dt, 16));

        r.pos_x   = track_x;
        r.pos_y   = track_y;
        r.heading = track_heading;
        r.vel_x   = vel_x_q;
        r.vel_y   = vel_y_q;
        return r;
    endfunction

    function automatic bit field_matches(input string name, input logic signed [63:0] want,
                                         input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Monitor all three channels on the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_offset_b  = '0;
            reg_step_time = STEP_TIME_DEFAULT;
            track_x       = '0;
            track_y       = '0;
            track_heading = '0;
            expected_poses.delete();
            fail_count    = 0;
            beats_checked = 0;
            start_beats   = 0;
            clamp_hits    = 0;
            pending      <= 0;
        end
        else
        begin
            // Register write; unknown indexes leave everything alone
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_OFFSET_B:  reg_offset_b  = cfg.data;
                    CFG_STEP_TIME: reg_step_time = cfg.data;
                    default: ;
                endcase
            end

            // Pose beat against the oldest prediction
            if (pose.valid && pose.ready)
            begin
                beats_checked++;
                if (expected_poses.size() == 0)
                begin
                    $error("pose beat with no sample outstanding");
                    fail_count++;
                end
                else
                begin
                    due_beat   = expected_poses.pop_front();
                    field_errs = 0;
                    if (!field_matches("pos_x", $signed(due_beat.pos_x), pose.pos_x))
                        field_errs++;
                    if (!field_matches("pos_y", $signed(due_beat.pos_y), pose.pos_y))
                        field_errs++;
                    if (!field_matches("heading", due_beat.heading, pose.heading))
                        field_errs++;
                    if (!field_matches("vel_x", $signed(due_beat.vel_x), pose.vel_x))
                        field_errs++;
                    if (!field_matches("vel_y", $signed(due_beat.vel_y), pose.vel_y))
                        field_errs++;
                    fail_count += field_errs;
                end
            end

            // Sample beat: predict its pose
            if (sample.valid && sample.ready)
            begin
                new_beat = integrate_sample(sample.start_req, sample.speed, sample.turn);
                expected_poses = {expected_poses, new_beat};
                if (sample.start_req)
                    start_beats++;
                if (new_beat.pos_x inside {32'sh7FFF_FFFF, 32'sh8000_0000} ||
                    new_beat.pos_y inside {32'sh7FFF_FFFF, 32'sh8000_0000})
                    clamp_hits++;
            end

            pending <= expected_poses.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/offset_unicycle_pose_integrator_test.sv =====
// ----------------------------------------------------------------------------
// offset_unicycle_pose_integrator_test
// Drives samples and register writes into the pose integrator with random
// idling on both channels; the checker beside the block predicts each pose.
// ----------------------------------------------------------------------------
`default_nettype none

module offset_unicycle_pose_integrator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import oupi_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 40;
    localparam int MAX_WAIT      = 14;
    localparam int READY_WAIT    = 40;
    localparam int PHASE_BEATS   = 130;
    localparam int RANDOM_PHASES = 6;
    localparam int STRAIGHT_RUN  = 50;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet = 1'b0;
    int   idle_cycles = 0;
    int   reg_writes = 0;

    int   fail_count;
    int   pending;
    int   beats_checked;
    int   start_beats;
    int   clamp_hits;

    oupi_in_if  sample_ch ();
    oupi_out_if pose_ch ();
    oupi_cfg_if cfg_ch ();

    offset_unicycle_pose_integrator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .pose   (pose_ch),
        .cfg    (cfg_ch)
    );

    oupi_pose_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample_ch),
        .pose          (pose_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked),
        .start_beats   (start_beats),
        .clamp_hits    (clamp_hits)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: too long without any beat on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (pose_ch.valid && pose_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("offset_unicycle_pose_integrator regression: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Pose receiver: stalls either ahead of the beat or while it waits
    initial
    begin
        int stall;
        pose_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall == 0)
                pose_ch.ready <= 1'b1;
            else
            begin
                pose_ch.ready <= 1'b0;
                if ($urandom_range(0, 1) == 1)
                    do @(posedge clk); while (!pose_ch.valid);
                repeat (stall) @(posedge clk);
                pose_ch.ready <= 1'b1;
            end
            do @(posedge clk); while (!(pose_ch.valid && pose_ch.ready));
        end
    end

    // One register write; valid is low again when the task returns
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
        @(posedge clk);
    endtask

    // One sample beat; valid stays high into the next beat when no gap is drawn
    task automatic send_sample(input logic st, input logic signed [15:0] spd,
                               input logic signed [15:0] trn);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            // half the gaps start only once the block is idle again
            if ($urandom_range(0, 1) == 1)
                for (int k = 0; k < READY_WAIT && !sample_ch.ready; k++)
                    @(posedge clk);
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.start_req <= st;
        sample_ch.speed     <= spd;
        sample_ch.turn      <= trn;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    task automatic close_burst();
        sample_ch.valid <= 1'b0;
    endtask

    // Wait for every predicted pose, then let the block fall idle
    task automatic settle();
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Full range, small magnitudes or the extremes
    function automatic logic signed [15:0] draw_field(input int span);
        logic [31:0] r;
        int          tmp;
        r = $urandom();
        case ($urandom_range(0, 3))
            0:
            begin
                tmp = int'($urandom_range(0, 2 * span)) - span;
                return tmp[15:0];
            end
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    default: return 16'sh0000;
                endcase
            end
            default: return r[15:0];
        endcase
    endfunction

    task automatic run_random_phase(input logic signed [15:0] b_val, input logic [15:0] dt_val);
        write_register(CFG_OFFSET_B, b_val);
        write_register(CFG_SPARE_2, 16'($urandom()));
        write_register(CFG_STEP_TIME, dt_val);
        write_register(CFG_SPARE_3, 16'($urandom()));
        quiet = ($urandom_range(0, 3) == 0);
        repeat (PHASE_BEATS)
            send_sample($urandom_range(0, 99) < 4, draw_field(2048), draw_field(512));
        close_burst();
        settle();
        quiet = 1'b0;
    endtask

    // Stimulus
    initial
    begin
        logic signed [15:0] b_val;
        logic        [15:0] dt_val;
        rst_n = 1'b0;
        sample_ch.valid     <= 1'b0;
        sample_ch.start_req <= 1'b0;
        sample_ch.speed     <= '0;
        sample_ch.turn      <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, register reset values: quadrant edges, wrap, ignored start fields
        send_sample(1'b1, 16'sh7FFF, 16'sh7FFF);
        send_sample(1'b0, 16'sh7FFF, 16'sh0000);
        send_sample(1'b0, 16'sh8000, 16'sh4000);
        send_sample(1'b0, 16'sh7FFF, 16'sh4000);
        send_sample(1'b0, 16'sh8000, 16'sh4000);
        send_sample(1'b0, 16'sh7FFF, 16'sh4000);
        send_sample(1'b0, 16'sh0000, -16'sd1);
        send_sample(1'b0, -16'sd1, 16'sh7FFF);
        send_sample(1'b0, 16'sd12345, 16'sh8000);
        send_sample(1'b1, 16'sh8000, 16'sh8000);
        send_sample(1'b0, 16'sh0000, 16'sh0000);
        close_burst();
        settle();

        // Directed, largest offset and step
        write_register(CFG_OFFSET_B, 16'sh8000);
        write_register(CFG_STEP_TIME, 16'hFFFF);
        send_sample(1'b0, 16'sh7FFF, 16'sh7FFF);
        send_sample(1'b0, 16'sh8000, 16'sh8000);
        send_sample(1'b0, 16'sh7FFF, 16'sh8000);
        send_sample(1'b0, 16'sh8000, 16'sh7FFF);
        send_sample(1'b0, 16'sd1, 16'sd1);
        send_sample(1'b1, 16'sh0000, 16'sh0000);
        send_sample(1'b0, 16'sh0000, 16'sh4000);
        send_sample(1'b0, 16'sh0000, -16'sd16384);
        send_sample(1'b0, 16'sh8000, 16'sh2000);
        close_burst();
        settle();

        // Random trajectories over a spread of register settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    b_val  = 16'sh7FFF;
                    dt_val = 16'hFFFF;
                end
                1:
                begin
                    b_val  = 16'sh8000;
                    dt_val = 16'h0000;
                end
                3:
                begin
                    b_val  = 16'sh0000;
                    dt_val = 16'h0001;
                end
                4:
                begin
                    b_val  = 16'($urandom());
                    dt_val = 16'hFFFF;
                end
                default:
                begin
                    b_val  = 16'($urandom());
                    dt_val = 16'($urandom());
                end
            endcase
            run_random_phase(b_val, dt_val);
        end

        // Back-to-back straight runs at full speed along positive x and negative y
        write_register(CFG_OFFSET_B, 16'sh0000);
        write_register(CFG_STEP_TIME, 16'hFFFF);
        quiet = 1'b1;
        send_sample(1'b1, 16'sh0000, 16'sh0000);
        repeat (STRAIGHT_RUN) send_sample(1'b0, 16'sh7FFF, 16'sh0000);
        send_sample(1'b1, 16'sh0000, 16'sh0000);
        send_sample(1'b0, 16'sh8000, 16'sh4000);
        repeat (STRAIGHT_RUN) send_sample(1'b0, 16'sh8000, 16'sh0000);
        close_burst();
        settle();
        quiet = 1'b0;

        repeat (END_CYCLES) @(posedge clk);
        $display("checked %0d pose beats (%0d start beats) across %0d register writes",
                 beats_checked, start_beats, reg_writes);
        $display("%0d beats held on a position limit", clamp_hits);
        if (fail_count == 0 && pending == 0)
            $display("offset_unicycle_pose_integrator regression: pass");
        else
            $display("offset_unicycle_pose_integrator regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
